[sv/slc_pkg.sv]
package slc_pkg;

  localparam int TILE_WIDTH_PIX = 128;
  localparam int DEPTH_PER_TILE = 256;
  localparam int MAX_LAND = 16;
  localparam int MAX_RESULTS = 31;

  localparam int LAND_W = $clog2(MAX_LAND + 1);
  localparam int CNT_W = $clog2(MAX_RESULTS);

  localparam logic [15:0] HALF_TILE = 16'(TILE_WIDTH_PIX / 2);
  localparam logic [15:0] FULL_TILE = 16'(TILE_WIDTH_PIX);
  localparam logic [20:0] DEPTH_STEP = 21'(DEPTH_PER_TILE);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CENTRE,
    ST_LEFT,
    ST_RIGHT
  } slc_state_t;

  typedef struct packed {
    logic       load;
    logic       emit;
    logic       restart;
    logic       outer;
    logic       last;
    slc_state_t side;
  } slc_ctl_t;

endpackage

[sv/slc_if.sv]
interface slc_in_if (input logic clk);
  logic               valid;
  logic               ready;
  logic [4:0]         land_width;
  logic [4:0]         land_height;
  logic [13:0]        src_x;
  logic [13:0]        src_w;
  logic [13:0]        src_h;
  logic [13:0]        anchor_x;
  logic signed [16:0] depth_offset;

  modport source (
    output valid, land_width, land_height, src_x, src_w, src_h, anchor_x, depth_offset,
    input  ready
  );
  modport sink (
    input  valid, land_width, land_height, src_x, src_w, src_h, anchor_x, depth_offset,
    output ready
  );
endinterface

interface slc_out_if (input logic clk);
  logic               valid;
  logic               ready;
  logic signed [15:0] slice_src_x;
  logic signed [15:0] slice_src_w;
  logic signed [15:0] slice_anchor_x;
  logic [13:0]        slice_anchor_y;
  logic signed [20:0] slice_depth;
  logic               last_slice;

  modport source (
    output valid, slice_src_x, slice_src_w, slice_anchor_x, slice_anchor_y, slice_depth,
           last_slice,
    input  ready
  );
  modport sink (
    input  valid, slice_src_x, slice_src_w, slice_anchor_x, slice_anchor_y, slice_depth,
           last_slice,
    output ready
  );
endinterface

[sv/slc_ctrl.sv]
module slc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [4:0]       in_land_width,
  input  logic [4:0]       in_land_height,
  output logic             out_valid,
  input  logic             out_ready,
  output slc_pkg::slc_ctl_t ctl
);
  import slc_pkg::*;

  slc_state_t        state_r, state_nxt;
  logic [LAND_W-1:0] lw_r, lw_nxt, lh_r, lh_nxt, lw_sat, lh_sat;
  logic [LAND_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept, free, emit, left_end, right_end, last_now;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign free      = !out_valid_r || out_ready;
  assign emit      = free && (state_r != ST_IDLE);

  assign lw_sat = (int'(in_land_width) > MAX_LAND) ? LAND_W'(MAX_LAND)
                                                   : LAND_W'(in_land_width);
  assign lh_sat = (int'(in_land_height) > MAX_LAND) ? LAND_W'(MAX_LAND)
                                                    : LAND_W'(in_land_height);

  assign left_end  = (idx_r == lw_r - LAND_W'(1));
  assign right_end = (idx_r == lh_r - LAND_W'(1));

  always_comb begin
    unique case (state_r)
      ST_CENTRE: last_now = (lw_r == LAND_W'(1)) && (lh_r == LAND_W'(1));
      ST_LEFT:   last_now = left_end && (lh_r == LAND_W'(1));
      ST_RIGHT:  last_now = right_end;
      default:   last_now = 1'b0;
    endcase
    if (cnt_r == CNT_W'(MAX_RESULTS - 1)) begin
      last_now = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    lw_nxt    = lw_r;
    lh_nxt    = lh_r;
    if (accept) begin
      lw_nxt  = lw_sat;
      lh_nxt  = lh_sat;
      cnt_nxt = '0;
      idx_nxt = '0;
      if (lw_sat != '0 && lh_sat != '0) begin
        state_nxt = ST_CENTRE;
      end
    end else if (emit) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      idx_nxt = idx_r + LAND_W'(1);
      unique case (state_r)
        ST_CENTRE: begin
          state_nxt = (lw_r > LAND_W'(1)) ? ST_LEFT : ST_RIGHT;
          idx_nxt   = LAND_W'(1);
        end
        ST_LEFT: begin
          if (left_end) begin
            state_nxt = ST_RIGHT;
            idx_nxt   = LAND_W'(1);
          end
        end
        default: ;
      endcase
      if (last_now) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  always_comb begin
    ctl.load    = accept;
    ctl.emit    = emit;
    ctl.side    = state_r;
    ctl.last    = last_now;
    ctl.restart = (state_r == ST_CENTRE) || ((state_r == ST_LEFT) && left_end);
    unique case (state_r)
      ST_LEFT:  ctl.outer = left_end;
      ST_RIGHT: ctl.outer = right_end;
      default:  ctl.outer = 1'b0;
    endcase
    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      lw_r        <= '0;
      lh_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      lw_r        <= lw_nxt;
      lh_r        <= lh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

[sv/slc_step.sv]
module slc_step (
  input  logic               clk,
  input  slc_pkg::slc_ctl_t  ctl,
  input  logic [13:0]        in_src_x,
  input  logic [13:0]        in_src_w,
  input  logic [13:0]        in_src_h,
  input  logic [13:0]        in_anchor_x,
  input  logic signed [16:0] in_depth_offset,
  output logic signed [15:0] slice_src_x,
  output logic signed [15:0] slice_src_w,
  output logic signed [15:0] slice_anchor_x,
  output logic [13:0]        slice_anchor_y,
  output logic signed [20:0] slice_depth,
  output logic               last_slice
);
  import slc_pkg::*;

  logic [15:0] base_r, sx_r, ax_r, swa_r, off_r, offn_r;
  logic [13:0] sh_r, ay_r;
  logic [20:0] dep_r, dacc_r;
  logic [15:0] x_nxt, w_nxt, a_nxt;
  logic [20:0] d_nxt;
  logic [15:0] x_r, w_r, a_r;
  logic [20:0] d_r;
  logic        last_r;

  always_comb begin
    unique case (ctl.side)
      ST_CENTRE: begin
        x_nxt = base_r - HALF_TILE;
        w_nxt = FULL_TILE;
        a_nxt = HALF_TILE;
        d_nxt = dep_r + DEPTH_STEP;
      end
      ST_LEFT: begin
        x_nxt = ctl.outer ? sx_r : base_r - offn_r;
        w_nxt = ctl.outer ? ax_r - off_r : HALF_TILE;
        a_nxt = ctl.outer ? ax_r : offn_r;
        d_nxt = dacc_r;
      end
      default: begin
        x_nxt = base_r + off_r;
        w_nxt = ctl.outer ? swa_r - off_r : HALF_TILE;
        a_nxt = 16'(0) - off_r;
        d_nxt = dacc_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      base_r <= 16'(in_src_x) + 16'(in_anchor_x);
      sx_r   <= 16'(in_src_x);
      ax_r   <= 16'(in_anchor_x);
      swa_r  <= 16'(in_src_w) - 16'(in_anchor_x);
      sh_r   <= in_src_h;
      dep_r  <= 21'(in_depth_offset);
    end
    if (ctl.emit) begin
      x_r    <= x_nxt;
      w_r    <= w_nxt;
      a_r    <= a_nxt;
      ay_r   <= sh_r;
      d_r    <= d_nxt;
      last_r <= ctl.last;
      if (ctl.restart) begin
        off_r  <= HALF_TILE;
        offn_r <= HALF_TILE + HALF_TILE;
        dacc_r <= dep_r - DEPTH_STEP;
      end else begin
        off_r  <= offn_r;
        offn_r <= offn_r + HALF_TILE;
        dacc_r <= dacc_r - DEPTH_STEP;
      end
    end
  end

  assign slice_src_x    = x_r;
  assign slice_src_w    = w_r;
  assign slice_anchor_x = a_r;
  assign slice_anchor_y = ay_r;
  assign slice_depth    = d_r;
  assign last_slice     = last_r;
endmodule

[sv/isometric_sprite_slicer.sv]
// Cuts one isometric sprite into vertical slice records: a centre slice one tile wide,
// then the left strips, then the right strips, the final record flagged by last_slice.
// An item is taken only while the block is idle; the sequencer then emits one record
// per cycle while the sink takes them, through a single step unit that adds half a tile
// to the strip offset and subtracts one tile depth each step. Footprint sizes above 16
// count as 16, and a sink that stalls the output register keeps the block busy for longer.
// A sprite with a zero footprint size gives no records.
module isometric_sprite_slicer (
  input logic       clk,
  input logic       rst_n,
  slc_in_if.sink    in_ch,
  slc_out_if.source out_ch
);
  import slc_pkg::*;

  slc_ctl_t ctl;

  slc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_land_width  (in_ch.land_width),
    .in_land_height (in_ch.land_height),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .ctl            (ctl)
  );

  slc_step u_step (
    .clk             (clk),
    .ctl             (ctl),
    .in_src_x        (in_ch.src_x),
    .in_src_w        (in_ch.src_w),
    .in_src_h        (in_ch.src_h),
    .in_anchor_x     (in_ch.anchor_x),
    .in_depth_offset (in_ch.depth_offset),
    .slice_src_x     (out_ch.slice_src_x),
    .slice_src_w     (out_ch.slice_src_w),
    .slice_anchor_x  (out_ch.slice_anchor_x),
    .slice_anchor_y  (out_ch.slice_anchor_y),
    .slice_depth     (out_ch.slice_depth),
    .last_slice      (out_ch.last_slice)
  );
endmodule

[sim/isometric_sprite_slicer_checker.sv]
module isometric_sprite_slicer_checker
  import slc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  slc_in_if    in_ch,
  slc_out_if   out_ch,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] src_x;
    logic signed [15:0] src_w;
    logic signed [15:0] anchor_x;
    logic [13:0]        anchor_y;
    logic signed [20:0] depth;
    logic               last;
  } slice_t;

  slice_t pending_slices[$];
  int     errors_seen = 0;
  int     waiting = 0;

  assign fail_count = errors_seen;
  assign pending = waiting;

  function automatic slice_t make_slice(int x, int w, int ax, logic [13:0] ay, int depth);
    slice_t s;
    s.src_x = 16'(x);
    s.src_w = 16'(w);
    s.anchor_x = 16'(ax);
    s.anchor_y = ay;
    s.depth = 21'(depth);
    s.last = 1'b0;
    return s;
  endfunction

  function automatic void slice_sprite(logic [4:0] lw_in, logic [4:0] lh_in,
                                       logic [13:0] sx_in, logic [13:0] sw_in,
                                       logic [13:0] sh_in, logic [13:0] ax_in,
                                       logic signed [16:0] dep_in);
    int     lw;
    int     lh;
    int     sx;
    int     sw;
    int     ax;
    int     dep;
    int     half;
    int     i;
    slice_t strips[$];
    lw = (lw_in > MAX_LAND) ? MAX_LAND : int'(lw_in);
    lh = (lh_in > MAX_LAND) ? MAX_LAND : int'(lh_in);
    if (lw == 0 || lh == 0) begin
      return;
    end
    sx = int'(sx_in);
    sw = int'(sw_in);
    ax = int'(ax_in);
    dep = int'(dep_in);
    half = TILE_WIDTH_PIX / 2;
    strips.insert(strips.size(), make_slice(sx + ax - half, TILE_WIDTH_PIX, half, sh_in,
                                            dep + DEPTH_PER_TILE));
    for (i = 1; i < lw && strips.size() < MAX_RESULTS; i++) begin
      if (i == lw - 1) begin
        strips.insert(strips.size(),
                      make_slice(sx, ax - half * i, ax, sh_in, dep - DEPTH_PER_TILE * i));
      end else begin
        strips.insert(strips.size(),
                      make_slice(sx + ax - half * (i + 1), half, half * (i + 1), sh_in,
                                 dep - DEPTH_PER_TILE * i));
      end
    end
    for (i = 1; i < lh && strips.size() < MAX_RESULTS; i++) begin
      strips.insert(strips.size(),
                    make_slice(sx + ax + half * i,
                               (i == lh - 1) ? (sw - ax - half * i) : half,
                               -(half * i), sh_in, dep - DEPTH_PER_TILE * i));
    end
    strips[strips.size() - 1].last = 1'b1;
    foreach (strips[k]) begin
      pending_slices.insert(pending_slices.size(), strips[k]);
    end
  endfunction

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      errors_seen++;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    slice_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        slice_sprite(in_ch.land_width, in_ch.land_height, in_ch.src_x, in_ch.src_w,
                     in_ch.src_h, in_ch.anchor_x, in_ch.depth_offset);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_slices.size() == 0) begin
          errors_seen++;
          $error("slice item: none expected, src_x %0d depth %0d arrived",
                 out_ch.slice_src_x, out_ch.slice_depth);
        end else begin
          want = pending_slices.pop_front();
          check_field("slice_src_x", want.src_x, out_ch.slice_src_x);
          check_field("slice_src_w", want.src_w, out_ch.slice_src_w);
          check_field("slice_anchor_x", want.anchor_x, out_ch.slice_anchor_x);
          check_field("slice_anchor_y", want.anchor_y, out_ch.slice_anchor_y);
          check_field("slice_depth", want.depth, out_ch.slice_depth);
          check_field("last_slice", want.last, out_ch.last_slice);
        end
      end
    end
    waiting <= pending_slices.size();
  end

endmodule

[sim/isometric_sprite_slicer_tb.sv]
module isometric_sprite_slicer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  bit   no_idle = 1'b0;

  slc_in_if  in_ch (clk);
  slc_out_if out_ch (clk);

  isometric_sprite_slicer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  isometric_sprite_slicer_checker slice_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic send_sprite(int lw, int lh, int sx, int sw, int sh, int ax, int dep);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.land_width <= 5'(lw);
    in_ch.land_height <= 5'(lh);
    in_ch.src_x <= 14'(sx);
    in_ch.src_w <= 14'(sw);
    in_ch.src_h <= 14'(sh);
    in_ch.anchor_x <= 14'(ax);
    in_ch.depth_offset <= 17'(dep);
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Holds off the sender until every slice already predicted has been taken.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    #20ms;
    $display("FAIL isometric_sprite_slicer");
    $finish;
  end

  initial begin
    int lw;
    int lh;
    int sw;
    int ax;
    int pick;
    rst_n = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.land_width <= '0;
    in_ch.land_height <= '0;
    in_ch.src_x <= '0;
    in_ch.src_w <= '0;
    in_ch.src_h <= '0;
    in_ch.anchor_x <= '0;
    in_ch.depth_offset <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_sprite(1, 1, 100, 256, 200, 128, 0);
    send_sprite(0, 5, 300, 700, 400, 350, 77);
    send_sprite(5, 0, 300, 700, 400, 350, -77);
    send_sprite(0, 0, 16383, 16383, 16383, 16383, -1);
    send_sprite(2, 2, 1000, 512, 300, 256, 1000);
    send_sprite(16, 16, 16383, 16383, 16383, 16383, 65535);
    send_sprite(31, 31, 0, 0, 0, 0, -65536);
    send_sprite(17, 1, 500, 2000, 1000, 1000, -1);
    send_sprite(1, 20, 500, 2000, 1000, 1000, 12345);
    send_sprite(3, 3, 4000, 300, 100, 0, 0);
    send_sprite(3, 3, 4000, 300, 100, 16383, 0);
    send_sprite(4, 2, 16383, 16383, 0, 8191, -65536);
    send_sprite(2, 4, 0, 0, 16383, 0, 65535);
    send_sprite(8, 8, 8000, 1024, 512, 512, -300);
    send_sprite(1, 2, 64, 128, 90, 64, 255);
    send_sprite(2, 1, 64, 128, 90, 64, -256);
    drain();

    for (int k = 0; k < 394; k++) begin
      no_idle = (k % 120) >= 95;
      if (k % 100 == 50) begin
        drain();
      end
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        lw = $urandom_range(1, 6);
        lh = $urandom_range(1, 6);
      end else if (pick < 14) begin
        lw = $urandom_range(0, 31);
        lh = 0;
        if (pick == 13) begin
          lh = lw;
          lw = 0;
        end
      end else if (pick < 17) begin
        lw = $urandom_range(1, 16);
        lh = $urandom_range(1, 16);
      end else begin
        lw = $urandom_range(0, 31);
        lh = $urandom_range(0, 31);
      end
      sw = $urandom_range(0, 16383);
      ax = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, sw);
      send_sprite(lw, lh, $urandom_range(0, 16383), sw, $urandom_range(0, 16383), ax,
                  $urandom_range(0, 131071));
    end
    no_idle = 1'b0;
    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS isometric_sprite_slicer");
    end else begin
      $display("FAIL isometric_sprite_slicer");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/slc_pkg.sv
sv/slc_if.sv
sv/slc_ctrl.sv
sv/slc_step.sv
sv/isometric_sprite_slicer.sv
sim/isometric_sprite_slicer_checker.sv
sim/isometric_sprite_slicer_tb.sv
